>>> sv/x64_instruction_byte_encoder_assert.svh
// Assertion macros for the x86-64 byte encoder.
// Expect a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef X64_INSTRUCTION_BYTE_ENCODER_ASSERT_SVH
`define X64_INSTRUCTION_BYTE_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define X64E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define X64E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/x64e_pkg.sv
// Shared types and constants for the x86-64 byte encoder.
// No dependencies; the front, queue, back, top level and bench import this package.
package x64e_pkg;

    localparam int X64E_MAX_BYTES   = 10;
    localparam int X64E_QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_PUSH    = 4'd1;
    localparam logic [3:0] OP_POP     = 4'd2;
    localparam logic [3:0] OP_MOV_IMM = 4'd3;
    localparam logic [3:0] OP_MOV     = 4'd4;
    localparam logic [3:0] OP_ADD     = 4'd5;
    localparam logic [3:0] OP_XOR     = 4'd6;
    localparam logic [3:0] OP_SUB_IMM = 4'd7;
    localparam logic [3:0] OP_LOAD    = 4'd8;
    localparam logic [3:0] OP_STORE   = 4'd9;

    // Operand sizes in bytes
    localparam logic [3:0] SZ_BYTE  = 4'd1;
    localparam logic [3:0] SZ_DWORD = 4'd4;
    localparam logic [3:0] SZ_QWORD = 4'd8;

    // Encoding bytes
    localparam logic [7:0] BYTE_NOP     = 8'h90;
    localparam logic [7:0] BYTE_PUSH    = 8'h50;
    localparam logic [7:0] BYTE_POP     = 8'h58;
    localparam logic [7:0] REX_W        = 8'h48;
    localparam logic [7:0] REX_WB       = 8'h49;
    localparam logic [7:0] REX_WR       = 8'h4C;
    localparam logic [7:0] REX_WRB      = 8'h4D;
    localparam logic [7:0] BYTE_MOV_IMM = 8'hB8;
    localparam logic [7:0] BYTE_ADD     = 8'h01;
    localparam logic [7:0] BYTE_XOR     = 8'h31;
    localparam logic [7:0] BYTE_GRP1    = 8'h81;
    localparam logic [7:0] BYTE_ESC     = 8'h0F;
    localparam logic [7:0] BYTE_MOVSX_B = 8'hBE;
    localparam logic [7:0] BYTE_MOVSXD  = 8'h63;
    localparam logic [7:0] BYTE_MOV_LD  = 8'h8B;
    localparam logic [7:0] BYTE_MOV_ST  = 8'h89;
    localparam logic [7:0] MODRM_REG    = 8'hC0;
    localparam logic [7:0] MODRM_SUB    = 8'hE8;
    localparam logic [7:0] MODRM_RBP32  = 8'h85;

    typedef logic [X64E_MAX_BYTES-1:0][7:0] t_bytes;

    // One classified instruction: byte 0 goes out first.
    typedef struct packed {
        logic       err;
        logic [3:0] len;
        t_bytes     bytes;
    } t_desc;

endpackage

>>> sv/x64e_instr_if.sv
// Instruction request channel and code byte channel.
// Depends on nothing; valid/ready handshake with a source and a sink side.
interface x64e_instr_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic [3:0]         dest_reg;
    logic [3:0]         src_reg;
    logic [3:0]         size_bytes;
    logic signed [31:0] immediate;

    modport source (output valid, operation, dest_reg, src_reg, size_bytes, immediate,
                    input ready);
    modport sink   (input valid, operation, dest_reg, src_reg, size_bytes, immediate,
                    output ready);
endinterface

interface x64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    logic       encode_error;

    modport source (output valid, code_byte, last_byte, encode_error, input ready);
    modport sink   (input valid, code_byte, last_byte, encode_error, output ready);
endinterface

>>> sv/x64e_front.sv
// Front end: accepts instruction requests and encodes them into byte descriptors.
// Depends on x64e_pkg and x64e_instr_if.
module x64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    x64e_instr_if.sink         i_instr,
    output logic               o_desc_valid,
    input  logic               i_desc_ready,
    output x64e_pkg::t_desc    o_desc
);
    import x64e_pkg::*;

    logic       r_valid;
    t_desc      r_desc;
    t_desc      n_desc;
    logic       accept;
    logic [3:0] d;
    logic [3:0] s;
    logic [3:0] sz;
    logic [31:0] imm;
    logic [7:0] modrm_rr;
    logic [7:0] modrm_mem;
    logic [7:0] rex_mem;
    logic       sz_ok;

    assign i_instr.ready = !r_valid || i_desc_ready;
    assign accept        = i_instr.valid && i_instr.ready;

    assign d   = i_instr.dest_reg;
    assign s   = i_instr.src_reg;
    assign sz  = i_instr.size_bytes;
    assign imm = unsigned'(i_instr.immediate);

    assign modrm_rr  = MODRM_REG | {2'b00, s[2:0], d[2:0]};
    assign modrm_mem = MODRM_RBP32 | {2'b00, d[2:0], 3'b000};
    assign rex_mem   = d[3] ? REX_WR : REX_W;
    assign sz_ok     = (sz == SZ_DWORD) || (sz == SZ_QWORD);

    always_comb begin
        // default: the error descriptor
        n_desc       = '0;
        n_desc.err   = 1'b1;
        n_desc.len   = 4'd1;
        unique case (i_instr.operation) inside
            OP_NOP: begin
                n_desc.err      = 1'b0;
                n_desc.bytes[0] = BYTE_NOP;
            end
            OP_PUSH, OP_POP: begin
                if (!d[3]) begin
                    n_desc.err      = 1'b0;
                    n_desc.bytes[0] = ((i_instr.operation == OP_PUSH) ? BYTE_PUSH : BYTE_POP)
                                      | {5'b00000, d[2:0]};
                end
            end
            OP_MOV_IMM: begin
                n_desc.err      = 1'b0;
                n_desc.len      = 4'd10;
                n_desc.bytes[0] = d[3] ? REX_WB : REX_W;
                n_desc.bytes[1] = BYTE_MOV_IMM | {5'b00000, d[2:0]};
                n_desc.bytes[2] = imm[7:0];
                n_desc.bytes[3] = imm[15:8];
                n_desc.bytes[4] = imm[23:16];
                n_desc.bytes[5] = imm[31:24];
            end
            OP_MOV: begin
                if (!d[3] && !s[3]) begin
                    n_desc.err      = 1'b0;
                    n_desc.len      = 4'd3;
                    n_desc.bytes[0] = REX_W;
                    n_desc.bytes[1] = BYTE_MOV_ST;
                    n_desc.bytes[2] = modrm_rr;
                end
            end
            OP_ADD: begin
                n_desc.err      = 1'b0;
                n_desc.len      = 4'd3;
                n_desc.bytes[0] = REX_W | {5'b00000, s[3], 1'b0, d[3]};
                n_desc.bytes[1] = BYTE_ADD;
                n_desc.bytes[2] = modrm_rr;
            end
            OP_XOR: begin
                if (!d[3] && !s[3] && sz_ok) begin
                    n_desc.err = 1'b0;
                    if (sz == SZ_QWORD) begin
                        n_desc.len      = 4'd3;
                        n_desc.bytes[0] = REX_W;
                        n_desc.bytes[1] = BYTE_XOR;
                        n_desc.bytes[2] = modrm_rr;
                    end else begin
                        n_desc.len      = 4'd2;
                        n_desc.bytes[0] = BYTE_XOR;
                        n_desc.bytes[1] = modrm_rr;
                    end
                end
            end
            OP_SUB_IMM: begin
                if (!d[3] && sz_ok) begin
                    n_desc.err = 1'b0;
                    if (sz == SZ_QWORD) begin
                        n_desc.len      = 4'd7;
                        n_desc.bytes[0] = REX_W;
                        n_desc.bytes[1] = BYTE_GRP1;
                        n_desc.bytes[2] = MODRM_SUB | {5'b00000, d[2:0]};
                        n_desc.bytes[3] = imm[7:0];
                        n_desc.bytes[4] = imm[15:8];
                        n_desc.bytes[5] = imm[23:16];
                        n_desc.bytes[6] = imm[31:24];
                    end else begin
                        n_desc.len      = 4'd6;
                        n_desc.bytes[0] = BYTE_GRP1;
                        n_desc.bytes[1] = MODRM_SUB | {5'b00000, d[2:0]};
                        n_desc.bytes[2] = imm[7:0];
                        n_desc.bytes[3] = imm[15:8];
                        n_desc.bytes[4] = imm[23:16];
                        n_desc.bytes[5] = imm[31:24];
                    end
                end
            end
            OP_LOAD: begin
                if (sz == SZ_BYTE) begin
                    n_desc.err      = 1'b0;
                    n_desc.len      = 4'd8;
                    n_desc.bytes[0] = rex_mem;
                    n_desc.bytes[1] = BYTE_ESC;
                    n_desc.bytes[2] = BYTE_MOVSX_B;
                    n_desc.bytes[3] = modrm_mem;
                    n_desc.bytes[4] = imm[7:0];
                    n_desc.bytes[5] = imm[15:8];
                    n_desc.bytes[6] = imm[23:16];
                    n_desc.bytes[7] = imm[31:24];
                end else if (sz_ok) begin
                    n_desc.err      = 1'b0;
                    n_desc.len      = 4'd7;
                    n_desc.bytes[0] = rex_mem;
                    n_desc.bytes[1] = (sz == SZ_DWORD) ? BYTE_MOVSXD : BYTE_MOV_LD;
                    n_desc.bytes[2] = modrm_mem;
                    n_desc.bytes[3] = imm[7:0];
                    n_desc.bytes[4] = imm[15:8];
                    n_desc.bytes[5] = imm[23:16];
                    n_desc.bytes[6] = imm[31:24];
                end
            end
            OP_STORE: begin
                n_desc.err      = 1'b0;
                n_desc.len      = 4'd7;
                n_desc.bytes[0] = rex_mem;
                n_desc.bytes[1] = BYTE_MOV_ST;
                n_desc.bytes[2] = modrm_mem;
                n_desc.bytes[3] = imm[7:0];
                n_desc.bytes[4] = imm[15:8];
                n_desc.bytes[5] = imm[23:16];
                n_desc.bytes[6] = imm[31:24];
            end
            default: begin
                n_desc.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_desc_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

endmodule

>>> sv/x64e_queue.sv
// Descriptor queue between the front and back ends.
// Depends on x64e_pkg; depth set by the DEPTH parameter.
module x64e_queue #(
    parameter int DEPTH = x64e_pkg::X64E_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  x64e_pkg::t_desc i_push_desc,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output x64e_pkg::t_desc o_pop_desc
);
    import x64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_desc   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_desc;
        end
    end

endmodule

>>> sv/x64e_back.sv
// Back end: serialises descriptors into code bytes through an output register.
// Depends on x64e_pkg, x64e_byte_if and the assertion macro header.
module x64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_desc_valid,
    output logic            o_desc_ready,
    input  x64e_pkg::t_desc i_desc,
    x64e_byte_if.source     o_code
);
    import x64e_pkg::*;

    logic       r_busy;
    t_desc      r_desc;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_err;

    t_desc      cur;
    logic [3:0] cur_idx;
    logic       have;
    logic       adv;
    logic       cur_last;

    // Work from the held descriptor, or straight from the queue head when idle
    assign cur      = r_busy ? r_desc : i_desc;
    assign cur_idx  = r_busy ? r_idx : 4'd0;
    assign have     = r_busy || i_desc_valid;
    assign adv      = have && (!r_out_valid || o_code.ready);
    assign cur_last = (cur_idx == cur.len - 4'd1);

    assign o_desc_ready = !r_busy && (!r_out_valid || o_code.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_busy      <= !cur_last;
                r_idx       <= cur_idx + 4'd1;
            end else if (o_code.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte <= cur.bytes[cur_idx];
            r_last <= cur_last;
            r_err  <= cur.err;
            if (!r_busy) begin
                r_desc <= i_desc;
            end
        end
    end

    assign o_code.valid        = r_out_valid;
    assign o_code.code_byte    = r_byte;
    assign o_code.last_byte    = r_last;
    assign o_code.encode_error = r_err;

`include "x64_instruction_byte_encoder_assert.svh"

    `X64E_ASSERT_NOW(a_err_alone, o_code.valid && o_code.encode_error, o_code.last_byte && (o_code.code_byte == 8'h00), "error beat must be a lone zero byte")
    `X64E_ASSERT_NOW(a_idx_range, r_busy, (r_idx != 4'd0) && (r_idx < r_desc.len), "byte index outside descriptor")
    `X64E_ASSERT_NEXT(a_stall_hold, r_out_valid && !o_code.ready, $stable(r_idx) && $stable(r_busy), "back end advanced while stalled")

endmodule

>>> sv/x64_instruction_byte_encoder.sv
// x86-64 instruction byte encoder, top level.
// Depends on x64e_pkg, x64e_instr_if, x64e_front, x64e_queue and x64e_back.
//
// Usage:
//   i_instr carries one instruction request per beat (operation, registers,
//   size, immediate). o_code returns its machine code one byte per beat, in
//   order, with last_byte on the final byte. An unsupported operation,
//   register or size gives a single beat: byte zero, last_byte and
//   encode_error set.
//   A request passes the front register, the queue and the back end's output
//   register before its first byte is valid. o_code moves one byte per cycle
//   while o_code.ready is high; an instruction of 1 to 10 bytes holds the
//   output until its last byte is taken; the back end's byte serialiser sets
//   this rate. The front end and queue keep taking requests while bytes drain,
//   so a request can be taken in consecutive cycles until the queue fills.
//   A stall on o_code holds the current beat; the queue absorbs up to
//   QUEUE_DEPTH encoded instructions plus one in the front register before
//   i_instr.ready drops.
//   Reset (synchronous, active low) empties the pipeline; nothing needs
//   clearing beyond the control flops.
module x64_instruction_byte_encoder #(
    parameter int QUEUE_DEPTH = x64e_pkg::X64E_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    x64e_instr_if.sink   i_instr,
    x64e_byte_if.source  o_code
);
    import x64e_pkg::*;

    // front -> queue
    logic  fq_valid;
    logic  fq_ready;
    t_desc fq_desc;
    // queue -> back
    logic  qb_valid;
    logic  qb_ready;
    t_desc qb_desc;

    // Classify and encode each request into a descriptor
    x64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr      (i_instr),
        .o_desc_valid (fq_valid),
        .i_desc_ready (fq_ready),
        .o_desc       (fq_desc)
    );

    // Decouple encoding from byte emission
    x64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_desc  (fq_desc),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_desc   (qb_desc)
    );

    // Emit bytes one beat at a time
    x64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (qb_valid),
        .o_desc_ready (qb_ready),
        .i_desc       (qb_desc),
        .o_code       (o_code)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the x86-64 instruction byte encoder.
// Depends on x64e_pkg, the channel interfaces and x64_instruction_byte_encoder.
module tb_top;
    import x64e_pkg::*;

    // One instruction request as it crosses the input channel.
    typedef struct packed {
        logic [3:0]         operation;
        logic [3:0]         dest_reg;
        logic [3:0]         src_reg;
        logic [3:0]         size_bytes;
        logic signed [31:0] immediate;
    } t_instr;

    // One machine-code beat as it leaves the output channel.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       encode_error;
    } t_code_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    x64e_instr_if instr_bus ();
    x64e_byte_if  code_bus ();

    x64_instruction_byte_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_bus),
        .o_code  (code_bus)
    );

    // Requests waiting to be driven, and the code beats owed by requests already taken.
    t_instr     instr_backlog[$];
    t_code_beat code_beats_due[$];
    t_instr     in_flight;

    // Idle rates in percent; changed only on the falling edge.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned instrs_taken   = 0;
    int unsigned beats_seen     = 0;
    int unsigned error_beats    = 0;

    t_code_beat want_beat;
    t_code_beat seen_beat;

    always #10 i_clk = ~i_clk;

    // Work out the code beats one request must produce. Every byte is pushed in
    // emission order; an illegal request collapses to a single error beat.
    function automatic void encode_to_beats(input t_instr rq);
        logic [7:0] code[$];
        logic       bad;
        logic       with_imm;
        logic       zero_dword;
        logic       with_disp;
        logic [7:0] rex_mem;
        logic [7:0] modrm_reg;
        logic [7:0] modrm_mem;
        t_code_beat beat;
        int         k;
        bad        = 1'b0;
        with_imm   = 1'b0;
        zero_dword = 1'b0;
        with_disp  = 1'b0;
        // REX.R carries bit 3 of the register field for the [rbp+disp32] forms.
        rex_mem   = rq.dest_reg[3] ? REX_WR : REX_W;
        modrm_reg = MODRM_REG | {2'b00, rq.src_reg[2:0], rq.dest_reg[2:0]};
        modrm_mem = MODRM_RBP32 | {2'b00, rq.dest_reg[2:0], 3'b000};
        case (rq.operation) inside
            OP_NOP: begin
                code.push_back(BYTE_NOP);
            end
            OP_PUSH, OP_POP: begin
                if (rq.dest_reg[3]) begin
                    bad = 1'b1;
                end else begin
                    code.push_back(((rq.operation == OP_PUSH) ? BYTE_PUSH : BYTE_POP)
                                   | {5'b00000, rq.dest_reg[2:0]});
                end
            end
            OP_MOV_IMM: begin
                // movabs form: the upper dword of the 64-bit immediate is zero.
                code.push_back(rq.dest_reg[3] ? REX_WB : REX_W);
                code.push_back(BYTE_MOV_IMM | {5'b00000, rq.dest_reg[2:0]});
                with_imm   = 1'b1;
                zero_dword = 1'b1;
            end
            OP_MOV: begin
                if (rq.dest_reg[3] || rq.src_reg[3]) begin
                    bad = 1'b1;
                end else begin
                    code = '{REX_W, BYTE_MOV_ST, modrm_reg};
                end
            end
            OP_ADD: begin
                // REX.R from the source, REX.B from the destination.
                code.push_back(REX_W | {5'b00000, rq.src_reg[3], 1'b0, rq.dest_reg[3]});
                code.push_back(BYTE_ADD);
                code.push_back(modrm_reg);
            end
            OP_XOR: begin
                if (rq.dest_reg[3] || rq.src_reg[3]
                    || (rq.size_bytes != SZ_DWORD && rq.size_bytes != SZ_QWORD)) begin
                    bad = 1'b1;
                end else begin
                    if (rq.size_bytes == SZ_QWORD) code.push_back(REX_W);
                    code.push_back(BYTE_XOR);
                    code.push_back(modrm_reg);
                end
            end
            OP_SUB_IMM: begin
                if (rq.dest_reg[3]
                    || (rq.size_bytes != SZ_DWORD && rq.size_bytes != SZ_QWORD)) begin
                    bad = 1'b1;
                end else begin
                    if (rq.size_bytes == SZ_QWORD) code.push_back(REX_W);
                    code.push_back(BYTE_GRP1);
                    code.push_back(MODRM_SUB | {5'b00000, rq.dest_reg[2:0]});
                    with_imm = 1'b1;
                end
            end
            OP_LOAD: begin
                if (rq.size_bytes == SZ_BYTE) begin
                    code = '{rex_mem, BYTE_ESC, BYTE_MOVSX_B};
                end else if (rq.size_bytes == SZ_DWORD) begin
                    code = '{rex_mem, BYTE_MOVSXD};
                end else if (rq.size_bytes == SZ_QWORD) begin
                    code = '{rex_mem, BYTE_MOV_LD};
                end else begin
                    bad = 1'b1;
                end
                with_disp = !bad;
            end
            OP_STORE: begin
                // Size is ignored: a store is always 64 bits.
                code      = '{rex_mem, BYTE_MOV_ST};
                with_disp = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (with_disp) code.push_back(modrm_mem);
        if (with_imm || with_disp) begin
            for (k = 0; k < 4; k++) code.push_back(rq.immediate[8*k +: 8]);
        end
        if (zero_dword) begin
            for (k = 0; k < 4; k++) code.push_back(8'h00);
        end
        if (bad || code.size() == 0) begin
            beat = '{code_byte: 8'h00, last_byte: 1'b1, encode_error: 1'b1};
            code_beats_due.push_back(beat);
        end else begin
            foreach (code[i]) begin
                beat = '{code_byte: code[i], last_byte: (i == code.size() - 1),
                         encode_error: 1'b0};
                code_beats_due.push_back(beat);
            end
        end
    endfunction

    task automatic queue_instr(input logic [3:0] op, input logic [3:0] dst,
                               input logic [3:0] src, input logic [3:0] sz,
                               input logic [31:0] imm);
        instr_backlog.push_back('{operation: op, dest_reg: dst, src_reg: src,
                                  size_bytes: sz, immediate: imm});
    endtask

    // Mostly well-formed requests with random content; the rest is noise:
    // unknown operations, extended registers where they are refused, bad sizes.
    task automatic queue_random_instrs(input int count);
        logic [3:0]  op;
        logic [3:0]  dst;
        logic [3:0]  src;
        logic [3:0]  sz;
        logic [31:0] imm;
        int          n;
        for (n = 0; n < count; n++) begin
            op  = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9, 0));
            dst = 4'($urandom_range(15, 0));
            src = 4'($urandom_range(15, 0));
            sz  = 4'($urandom_range(8, 0));
            case (op) inside
                OP_PUSH, OP_POP, OP_MOV, OP_XOR, OP_SUB_IMM: begin
                    if ($urandom_range(99) < 85) begin
                        dst[3] = 1'b0;
                        src[3] = 1'b0;
                    end
                end
                default: ;
            endcase
            if ($urandom_range(99) < 85) begin
                if (op == OP_XOR || op == OP_SUB_IMM) begin
                    sz = $urandom_range(1) ? SZ_QWORD : SZ_DWORD;
                end else if (op == OP_LOAD) begin
                    case ($urandom_range(2))
                        0:       sz = SZ_BYTE;
                        1:       sz = SZ_DWORD;
                        default: sz = SZ_QWORD;
                    endcase
                end
            end
            // Lean on the corner values of the immediate now and then.
            case ($urandom_range(19))
                0:       imm = 32'h0000_0000;
                1:       imm = 32'hFFFF_FFFF;
                2:       imm = 32'h7FFF_FFFF;
                3:       imm = 32'h8000_0000;
                default: imm = $urandom;
            endcase
            queue_instr(op, dst, src, sz, imm);
        end
    endtask

    // Hold until the backlog is empty, nothing sits on the input and every
    // owed beat has come back.
    task automatic wait_for_drain();
        while (instr_backlog.size() != 0 || instr_bus.valid || code_beats_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: record the beat taken at this edge, then present the next
    // request or drop valid. Valid is only touched once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            instr_bus.valid <= 1'b0;
        end else begin
            if (instr_bus.valid && instr_bus.ready) begin
                encode_to_beats(in_flight);
                instrs_taken++;
            end
            if (!instr_bus.valid || instr_bus.ready) begin
                if (instr_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = instr_backlog.pop_front();
                    instr_bus.operation  <= in_flight.operation;
                    instr_bus.dest_reg   <= in_flight.dest_reg;
                    instr_bus.src_reg    <= in_flight.src_reg;
                    instr_bus.size_bytes <= in_flight.size_bytes;
                    instr_bus.immediate  <= in_flight.immediate;
                    instr_bus.valid      <= 1'b1;
                end else begin
                    instr_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Code beat monitor: check each taken beat against the oldest owed one,
    // then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_bus.ready <= 1'b0;
        end else begin
            if (code_bus.valid && code_bus.ready) begin
                seen_beat = '{code_byte: code_bus.code_byte, last_byte: code_bus.last_byte,
                              encode_error: code_bus.encode_error};
                beats_seen++;
                if (seen_beat.encode_error === 1'b1) error_beats++;
                if (code_beats_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, got byte %02h last %b err %b",
                             $time, seen_beat.code_byte, seen_beat.last_byte,
                             seen_beat.encode_error);
                end else begin
                    want_beat = code_beats_due.pop_front();
                    if (seen_beat.code_byte !== want_beat.code_byte) begin
                        mismatch_count++;
                        $display("%0t: code_byte expected %02h got %02h", $time,
                                 want_beat.code_byte, seen_beat.code_byte);
                    end
                    if (seen_beat.last_byte !== want_beat.last_byte) begin
                        mismatch_count++;
                        $display("%0t: last_byte expected %b got %b", $time,
                                 want_beat.last_byte, seen_beat.last_byte);
                    end
                    if (seen_beat.encode_error !== want_beat.encode_error) begin
                        mismatch_count++;
                        $display("%0t: encode_error expected %b got %b", $time,
                                 want_beat.encode_error, seen_beat.encode_error);
                    end
                end
            end
            code_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus sequence: reset, a directed sweep, then three random phases with
    // the idling moved from one side to the other and finally switched off.
    initial begin
        instr_bus.valid      = 1'b0;
        instr_bus.operation  = OP_NOP;
        instr_bus.dest_reg   = 4'd0;
        instr_bus.src_reg    = 4'd0;
        instr_bus.size_bytes = 4'd0;
        instr_bus.immediate  = 32'sd0;
        code_bus.ready       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 62;
        // Directed sweep: every operation, register and immediate extremes,
        // extended registers where refused, bad sizes and unknown operations.
        queue_instr(OP_NOP,     4'd0,  4'd0,  4'd0,     32'h0);
        queue_instr(OP_PUSH,    4'd0,  4'd0,  4'd0,     32'h0);
        queue_instr(OP_POP,     4'd7,  4'd0,  4'd0,     32'h0);
        queue_instr(OP_PUSH,    4'd8,  4'd0,  4'd0,     32'h0);
        queue_instr(OP_POP,     4'd15, 4'd0,  4'd0,     32'h0);
        queue_instr(OP_MOV_IMM, 4'd0,  4'd0,  4'd0,     32'h7FFF_FFFF);
        queue_instr(OP_MOV_IMM, 4'd15, 4'd15, 4'd8,     32'h8000_0000);
        queue_instr(OP_MOV,     4'd7,  4'd0,  4'd0,     32'h0);
        queue_instr(OP_MOV,     4'd0,  4'd8,  4'd0,     32'h0);
        queue_instr(OP_ADD,     4'd15, 4'd15, 4'd0,     32'h0);
        queue_instr(OP_ADD,     4'd3,  4'd12, 4'd0,     32'h0);
        queue_instr(OP_XOR,     4'd7,  4'd7,  SZ_DWORD, 32'h0);
        queue_instr(OP_XOR,     4'd0,  4'd0,  SZ_QWORD, 32'h0);
        queue_instr(OP_XOR,     4'd1,  4'd2,  4'd0,     32'h0);
        queue_instr(OP_SUB_IMM, 4'd7,  4'd0,  SZ_QWORD, 32'hFFFF_FFFF);
        queue_instr(OP_SUB_IMM, 4'd0,  4'd0,  SZ_DWORD, 32'h0);
        queue_instr(OP_SUB_IMM, 4'd9,  4'd0,  SZ_QWORD, 32'h1234_5678);
        queue_instr(OP_LOAD,    4'd12, 4'd0,  SZ_BYTE,  32'hFFFF_FFFF);
        queue_instr(OP_LOAD,    4'd3,  4'd0,  SZ_DWORD, 32'h8000_0000);
        queue_instr(OP_LOAD,    4'd15, 4'd0,  SZ_QWORD, 32'h7FFF_FFFF);
        queue_instr(OP_LOAD,    4'd2,  4'd0,  4'd5,     32'h10);
        queue_instr(OP_STORE,   4'd9,  4'd0,  4'd0,     32'h1234_5678);
        queue_instr(OP_STORE,   4'd0,  4'd0,  SZ_QWORD, 32'hFFFF_FFF8);
        queue_instr(4'd15,      4'd0,  4'd0,  4'd0,     32'h0);
        queue_instr(4'd10,      4'd5,  4'd5,  4'd4,     32'h0);
        // Hold the stimulus until every owed beat has come back.
        wait_for_drain();

        queue_random_instrs(128);
        wait_for_drain();

        send_idle_pct = 62;
        recv_idle_pct = 6;
        queue_random_instrs(128);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_instrs(128);
        wait_for_drain();

        // Let any stray beat surface before judging.
        repeat (20) @(negedge i_clk);
        $display("Encoded %0d requests into %0d code beats (%0d error beats),",
                 instrs_taken, beats_seen, error_beats);
        $display("with idling on the sender side, the receiver side and neither.");
        if (mismatch_count == 0 && code_beats_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d beats still owed", mismatch_count,
                     code_beats_due.size());
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("Timed out with %0d beats still owed", code_beats_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule
